// File: rtl/core/btoob_pkg.sv
// shared types and constants for the out-of-band record parser
`timescale 1ns / 1ps

package btoob_pkg;

  // record layout
  localparam logic [15:0] HEADER_BYTES = 16'd8;
  localparam logic [7:0]  COD_TYPE     = 8'h0d;

  // reset values of the type registers
  localparam logic [7:0] SEARCH_RESET   = 8'h09;
  localparam logic [7:0] FALLBACK_RESET = 8'h08;

  // configuration register indexes
  localparam logic [7:0] CFG_SEARCH_TYPE   = 8'd0;
  localparam logic [7:0] CFG_FALLBACK_TYPE = 8'd1;

  // error codes
  localparam logic [1:0] ERR_OK        = 2'd0;
  localparam logic [1:0] ERR_SHORT     = 2'd1;
  localparam logic [1:0] ERR_MISMATCH  = 2'd2;
  localparam logic [1:0] ERR_TRUNCATED = 2'd3;

  // one parse result
  typedef struct packed {
    logic        payload_valid;
    logic [1:0]  error_code;
    logic [47:0] device_address;
    logic [23:0] class_of_device;
    logic        class_found;
    logic        match_found;
    logic        match_is_primary;
    logic [15:0] match_offset;
    logic [7:0]  match_length;
    logic [15:0] byte_count;
  } result_t;

endpackage

// File: rtl/core/btoob_parser.sv
// per-record parse state and per-byte update
`timescale 1ns / 1ps

module btoob_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 last_byte_i,
  input  logic [7:0]           search_type_i,
  input  logic [7:0]           fallback_type_i,
  output btoob_pkg::result_t   result_o
);

  logic [15:0] pos_q, pos_d, pos_u;
  logic [15:0] total_q, total_d, total_u;
  logic [15:0] nes_q, nes_d, nes_u;
  logic [15:0] cs_q, cs_d, cs_u;
  logic [7:0]  clen_q, clen_d, clen_u;
  logic        exp_type_q, exp_type_d, exp_type_u;
  logic [47:0] addr_q, addr_d, addr_u;
  logic [23:0] cls_q, cls_d, cls_u;
  logic [1:0]  cls_left_q, cls_left_d, cls_left_u;
  logic        cls_seen_q, cls_seen_d, cls_seen_u;
  logic        pri_seen_q, pri_seen_d, pri_seen_u;
  logic        fb_seen_q, fb_seen_d, fb_seen_u;
  logic [23:0] pri_ol_q, pri_ol_d, pri_ol_u;
  logic [23:0] fb_ol_q, fb_ol_d, fb_ol_u;
  logic        trunc_q, trunc_d, trunc_u;
  logic        ovf_q, ovf_d, ovf_u;

  logic [16:0] nxt_start;
  logic [16:0] type_pos;
  logic [1:0]  cls_idx;
  logic [7:0]  len_m1;
  logic [23:0] ol;
  logic [1:0]  err;
  logic [23:0] sel_ol;

  assign nxt_start = {1'b0, pos_q} + 17'd1 + {9'b0, data_byte_i};
  assign type_pos  = {1'b0, cs_q} + 17'd1;
  assign cls_idx   = pos_q[1:0] - cs_q[1:0] - 2'd2;
  assign len_m1    = clen_q - 8'd1;
  assign ol        = {cs_q, clen_q};

  // byte update
  always_comb begin
    pos_u      = pos_q;
    total_u    = total_q;
    nes_u      = nes_q;
    cs_u       = cs_q;
    clen_u     = clen_q;
    exp_type_u = exp_type_q;
    addr_u     = addr_q;
    cls_u      = cls_q;
    cls_left_u = cls_left_q;
    cls_seen_u = cls_seen_q;
    pri_seen_u = pri_seen_q;
    fb_seen_u  = fb_seen_q;
    pri_ol_u   = pri_ol_q;
    fb_ol_u    = fb_ol_q;
    trunc_u    = trunc_q;
    ovf_u      = ovf_q;

    if (!ovf_q) begin
      if (pos_q == 16'd0) begin
        total_u = {8'b0, data_byte_i};
      end else if (pos_q == 16'd1) begin
        total_u = {data_byte_i, total_q[7:0]};
      end else if (pos_q < btoob_pkg::HEADER_BYTES) begin
        addr_u = addr_q | ({40'b0, data_byte_i} << {pos_q[2:0] - 3'd2, 3'b0});
      end else if (!trunc_q) begin
        if (cls_left_q != 2'd0) begin
          // class of device data bytes
          if (cls_idx != 2'd3) begin
            cls_u = cls_q | ({16'b0, data_byte_i} << {cls_idx, 3'b0});
          end
          cls_left_u = cls_left_q - 2'd1;
        end else if (exp_type_q && ({1'b0, pos_q} == type_pos)) begin
          // entry type byte
          exp_type_u = 1'b0;
          if (data_byte_i == search_type_i && !pri_seen_q) begin
            pri_seen_u = 1'b1;
            pri_ol_u   = ol;
          end
          if (data_byte_i == fallback_type_i && !fb_seen_q) begin
            fb_seen_u = 1'b1;
            fb_ol_u   = ol;
          end
          if (data_byte_i == btoob_pkg::COD_TYPE && !cls_seen_q) begin
            cls_seen_u = 1'b1;
            cls_u      = 24'd0;
            cls_left_u = (len_m1 > 8'd3) ? 2'd3 : len_m1[1:0];
          end
        end else if (pos_q == nes_q) begin
          // entry length byte
          cs_u       = pos_q;
          clen_u     = data_byte_i;
          exp_type_u = (data_byte_i != 8'd0);
          if (nxt_start[16]) begin
            trunc_u = 1'b1;
          end else begin
            nes_u = nxt_start[15:0];
          end
        end
      end
    end

    // saturating byte counter
    if (pos_q == 16'hffff) begin
      ovf_u = 1'b1;
    end else begin
      pos_u = pos_q + 16'd1;
    end
  end

  // record checks and result fields
  always_comb begin
    if (pos_u < btoob_pkg::HEADER_BYTES) begin
      err = btoob_pkg::ERR_SHORT;
    end else if (ovf_u || pos_u != total_u) begin
      err = btoob_pkg::ERR_MISMATCH;
    end else if (trunc_u || nes_u != pos_u) begin
      err = btoob_pkg::ERR_TRUNCATED;
    end else begin
      err = btoob_pkg::ERR_OK;
    end

    sel_ol = pri_seen_u ? pri_ol_u : fb_ol_u;

    result_o            = '0;
    result_o.error_code = err;
    result_o.byte_count = pos_u;
    if (err == btoob_pkg::ERR_OK) begin
      result_o.payload_valid   = 1'b1;
      result_o.device_address  = addr_u;
      result_o.class_of_device = cls_seen_u ? cls_u : 24'd0;
      result_o.class_found     = cls_seen_u;
      if (pri_seen_u || fb_seen_u) begin
        result_o.match_found      = 1'b1;
        result_o.match_is_primary = pri_seen_u;
        result_o.match_offset     = sel_ol[23:8];
        result_o.match_length     = sel_ol[7:0];
      end
    end
  end

  // next state: start over after the last byte
  always_comb begin
    pos_d      = pos_q;
    total_d    = total_q;
    nes_d      = nes_q;
    cs_d       = cs_q;
    clen_d     = clen_q;
    exp_type_d = exp_type_q;
    addr_d     = addr_q;
    cls_d      = cls_q;
    cls_left_d = cls_left_q;
    cls_seen_d = cls_seen_q;
    pri_seen_d = pri_seen_q;
    fb_seen_d  = fb_seen_q;
    pri_ol_d   = pri_ol_q;
    fb_ol_d    = fb_ol_q;
    trunc_d    = trunc_q;
    ovf_d      = ovf_q;
    if (step_i) begin
      if (last_byte_i) begin
        pos_d      = 16'd0;
        total_d    = 16'd0;
        nes_d      = btoob_pkg::HEADER_BYTES;
        cs_d       = 16'd0;
        clen_d     = 8'd0;
        exp_type_d = 1'b0;
        addr_d     = 48'd0;
        cls_d      = 24'd0;
        cls_left_d = 2'd0;
        cls_seen_d = 1'b0;
        pri_seen_d = 1'b0;
        fb_seen_d  = 1'b0;
        pri_ol_d   = 24'd0;
        fb_ol_d    = 24'd0;
        trunc_d    = 1'b0;
        ovf_d      = 1'b0;
      end else begin
        pos_d      = pos_u;
        total_d    = total_u;
        nes_d      = nes_u;
        cs_d       = cs_u;
        clen_d     = clen_u;
        exp_type_d = exp_type_u;
        addr_d     = addr_u;
        cls_d      = cls_u;
        cls_left_d = cls_left_u;
        cls_seen_d = cls_seen_u;
        pri_seen_d = pri_seen_u;
        fb_seen_d  = fb_seen_u;
        pri_ol_d   = pri_ol_u;
        fb_ol_d    = fb_ol_u;
        trunc_d    = trunc_u;
        ovf_d      = ovf_u;
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= 16'd0;
      total_q    <= 16'd0;
      nes_q      <= btoob_pkg::HEADER_BYTES;
      cs_q       <= 16'd0;
      clen_q     <= 8'd0;
      exp_type_q <= 1'b0;
      addr_q     <= 48'd0;
      cls_q      <= 24'd0;
      cls_left_q <= 2'd0;
      cls_seen_q <= 1'b0;
      pri_seen_q <= 1'b0;
      fb_seen_q  <= 1'b0;
      pri_ol_q   <= 24'd0;
      fb_ol_q    <= 24'd0;
      trunc_q    <= 1'b0;
      ovf_q      <= 1'b0;
    end else begin
      pos_q      <= pos_d;
      total_q    <= total_d;
      nes_q      <= nes_d;
      cs_q       <= cs_d;
      clen_q     <= clen_d;
      exp_type_q <= exp_type_d;
      addr_q     <= addr_d;
      cls_q      <= cls_d;
      cls_left_q <= cls_left_d;
      cls_seen_q <= cls_seen_d;
      pri_seen_q <= pri_seen_d;
      fb_seen_q  <= fb_seen_d;
      pri_ol_q   <= pri_ol_d;
      fb_ol_q    <= fb_ol_d;
      trunc_q    <= trunc_d;
      ovf_q      <= ovf_d;
    end
  end

endmodule

// File: rtl/core/bt_oob_eir_record_parser.sv
// top level of the out-of-band record parser
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+----------------------------------
//   in      | input     | in_valid_i / in_ready_o | data_byte_i, last_byte_i
//   out     | output    | out_valid_o/out_ready_i | payload_valid_o ... byte_count_o
//   cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// one byte word per cycle sustained while no last word waits for the result slot; a word
// first goes into the input register, then the parse state updates in a single pass and
// the last word of a record loads the result register, which drives the outputs.
// reset clears the parse state and sets the type registers to 9 and 8.
// a stalled result holds back only a last word and the words behind it; other words keep flowing.
`timescale 1ns / 1ps

module bt_oob_eir_record_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        payload_valid_o,
  output logic [1:0]  error_code_o,
  output logic [47:0] device_address_o,
  output logic [23:0] class_of_device_o,
  output logic        class_found_o,
  output logic        match_found_o,
  output logic        match_is_primary_o,
  output logic [15:0] match_offset_o,
  output logic [7:0]  match_length_o,
  output logic [15:0] byte_count_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  logic       in_vld_q, in_vld_d;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       step;
  logic       out_free;
  logic       out_vld_q, out_vld_d;
  logic [7:0] search_q, fallback_q;

  btoob_pkg::result_t res;
  btoob_pkg::result_t res_q;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      search_q   <= btoob_pkg::SEARCH_RESET;
      fallback_q <= btoob_pkg::FALLBACK_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        btoob_pkg::CFG_SEARCH_TYPE:   search_q   <= cfg_data_i;
        btoob_pkg::CFG_FALLBACK_TYPE: fallback_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register; a last word waits for a free result slot
  assign out_free   = !out_vld_q || out_ready_i;
  assign step       = in_vld_q && (!in_last_q || out_free);
  assign in_ready_o = !in_vld_q || step;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_ready_o) begin
      in_vld_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= data_byte_i;
      in_last_q <= last_byte_i;
    end
  end

  // parse state
  btoob_parser u_parser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (step),
    .data_byte_i     (in_byte_q),
    .last_byte_i     (in_last_q),
    .search_type_i   (search_q),
    .fallback_type_i (fallback_q),
    .result_o        (res)
  );

  // result register
  always_comb begin
    out_vld_d = out_vld_q;
    if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
    if (step && in_last_q) begin
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && in_last_q) begin
      res_q <= res;
    end
  end

  assign out_valid_o        = out_vld_q;
  assign payload_valid_o    = res_q.payload_valid;
  assign error_code_o       = res_q.error_code;
  assign device_address_o   = res_q.device_address;
  assign class_of_device_o  = res_q.class_of_device;
  assign class_found_o      = res_q.class_found;
  assign match_found_o      = res_q.match_found;
  assign match_is_primary_o = res_q.match_is_primary;
  assign match_offset_o     = res_q.match_offset;
  assign match_length_o     = res_q.match_length;
  assign byte_count_o       = res_q.byte_count;

endmodule
